@@ hw/rtl/tsbw_pkg.sv @@
// ----------------------------------------------------------------------------
// tsbw_pkg
// Shared constants and types for the terrain splat brush weight block.
// ----------------------------------------------------------------------------
`default_nettype none
package tsbw_pkg;

  localparam int FractionBitsDefault = 8;
  localparam int CoordW  = 24;
  localparam int WeightW = 16;
  localparam int NumLayers = 4;
  localparam int WeightsW = WeightW * NumLayers;

  // Square root chain: 50-bit radicand padded to 52 bits, two bits per cell.
  localparam int SqCells = 26;
  localparam int SqRadW  = 2 * SqCells;
  localparam int SqRemW  = 29;
  localparam int RootW   = SqCells;

  localparam int RadW    = 24;
  localparam int GainW   = 24;
  localparam int MagW    = 37;
  localparam int ProdW   = MagW + GainW;

  localparam int CfgAddrW = 5;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Z = 3'd1,
    REG_RADIUS   = 3'd2,
    REG_GAIN     = 3'd3,
    REG_MODE     = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_LAYER_A = 3'd0,
    MODE_LAYER_B = 3'd1,
    MODE_LAYER_C = 3'd2,
    MODE_LAYER_D = 3'd3,
    MODE_ERASE   = 3'd4
  } mode_t;

  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_z;
    logic [RadW-1:0]          radius;
    logic [GainW-1:0]         gain;
    logic [2:0]               mode;
  } cfg_t;

endpackage
`default_nettype wire

@@ hw/rtl/terrain_splat_brush_weight_top.sv @@
// ----------------------------------------------------------------------------
// terrain_splat_brush_weight_top
// Terrain splat brush: updates the selected layer weight (or clears all four in erase mode) of one vertex per item.
// ----------------------------------------------------------------------------
// Usage:
// Vertex items enter on the in_ stream (position and four weights) and one
// result item with the four updated weights leaves on the out_ stream for each.
// The brush is set through the cfg_ APB-style port while the block is idle.
// Throughput is one item per cycle while the receiver does not stall. An item
// passes through four front stages (input register, difference, squares, sum),
// a 26-cell square root chain, a 26 + FRACTION_BITS cell divider chain, four
// weight stages, then the output register.
// A skid register sits behind the output register; when the receiver stalls,
// the skid takes the next item and in_tready drops, freezing every cell.
// Reset clears all valid bits and loads the register reset values; no
// item is lost or repeated across stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module terrain_splat_brush_weight_top
  import tsbw_pkg::*;
#(
  parameter int FRACTION_BITS = FractionBitsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // vertex_x, vertex_z, layer_weight_a, layer_weight_b, layer_weight_c, layer_weight_d
  input  wire logic [111:0]        in_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // new_weight_a, new_weight_b, new_weight_c, new_weight_d
  output logic [63:0]              out_tdata,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CfgAddrW-1:0] cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  localparam int DvdW = RootW + FRACTION_BITS;
  localparam int WmaxI = ((255 << FRACTION_BITS) > 65535) ? 65535 : (255 << FRACTION_BITS);

  cfg_t cfg;
  logic en;

  tsbw_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .cfg(cfg)
  );

  // Front stages: absolute differences, squares, sum.
  logic signed [CoordW:0] dx, dz;
  logic                   a_v_r;
  logic [CoordW-1:0]      a_x_r, a_z_r;
  logic [CoordW:0]        a_ax_r, a_az_r;
  logic [WeightsW-1:0]    a_w_r;
  logic [2*CoordW:0]      b_sx_r, b_sz_r;
  logic [SqRadW-1:0]      c_sum_r;

  always_comb begin
    dx = $signed({a_x_r[CoordW-1], a_x_r}) - $signed({cfg.center_x[CoordW-1], cfg.center_x});
    dz = $signed({a_z_r[CoordW-1], a_z_r}) - $signed({cfg.center_z[CoordW-1], cfg.center_z});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_tvalid;
    end
  end

  // The input register stage holds the raw item; differences are formed after it.
  logic                   p_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r   <= in_tdata[23:0];
      a_z_r   <= in_tdata[47:24];
      a_w_r   <= in_tdata[111:48];
      a_ax_r  <= dx[CoordW] ? (CoordW+1)'(-dx) : (CoordW+1)'(dx);
      a_az_r  <= dz[CoordW] ? (CoordW+1)'(-dz) : (CoordW+1)'(dz);
      b_sx_r  <= (2*CoordW+1)'(a_ax_r * a_ax_r);
      b_sz_r  <= (2*CoordW+1)'(a_az_r * a_az_r);
      c_sum_r <= SqRadW'(b_sx_r) + SqRadW'(b_sz_r);
    end
  end

  // The p, q and r stages carry the valid bit and weights alongside a_ax_r,
  // the squares and their sum.
  logic q_v_r, r_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= 1'b0;
      r_v_r <= 1'b0;
    end else if (en) begin
      q_v_r <= p_v_r;
      r_v_r <= q_v_r;
    end
  end

  logic [WeightsW-1:0] p_w_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_w_r <= a_w_r;
    end
  end

  // Square root chain.
  logic [SqCells:0]    sq_v;
  logic [SqRadW-1:0]   sq_rad [SqCells+1];
  logic [SqRemW-1:0]   sq_rem [SqCells+1];
  logic [RootW-1:0]    sq_root[SqCells+1];
  logic [WeightsW-1:0] sq_w   [SqCells+1];

  // Weights are registered behind the difference stage, matching the squares.
  logic [WeightsW-1:0] q_w_r, r_w_r;
  always_ff @(posedge clk) begin
    if (en) begin
      q_w_r <= p_w_r;
      r_w_r <= q_w_r;
    end
  end

  assign sq_v[0]    = r_v_r;
  assign sq_rad[0]  = c_sum_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_w[0]    = r_w_r;

  for (genvar i = 0; i < SqCells; i++) begin : g_sq
    tsbw_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_i(sq_v[i]), .rad_i(sq_rad[i]), .rem_i(sq_rem[i]),
      .root_i(sq_root[i]), .wgt_i(sq_w[i]),
      .valid_o(sq_v[i+1]), .rad_o(sq_rad[i+1]), .rem_o(sq_rem[i+1]),
      .root_o(sq_root[i+1]), .wgt_o(sq_w[i+1])
    );
  end

  // Divider chain: ratio = (dist << F) / radius.
  logic [DvdW:0]       dv_v;
  logic [DvdW-1:0]     dv_d [DvdW+1];
  logic [RadW-1:0]     dv_r [DvdW+1];
  logic [WeightsW-1:0] dv_w [DvdW+1];

  assign dv_v[0] = sq_v[SqCells];
  assign dv_d[0] = {sq_root[SqCells], FRACTION_BITS'(0)};
  assign dv_r[0] = '0;
  assign dv_w[0] = sq_w[SqCells];

  for (genvar j = 0; j < DvdW; j++) begin : g_dv
    tsbw_div_cell #(.DvdW(DvdW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .radius(cfg.radius),
      .valid_i(dv_v[j]), .dvd_i(dv_d[j]), .rem_i(dv_r[j]), .wgt_i(dv_w[j]),
      .valid_o(dv_v[j+1]), .dvd_o(dv_d[j+1]), .rem_o(dv_r[j+1]), .wgt_o(dv_w[j+1])
    );
  end

  logic                fin_v;
  logic [WeightsW-1:0] fin_w;

  tsbw_weight_unit #(.FractionBits(FRACTION_BITS), .DvdW(DvdW)) u_weight (
    .clk(clk), .rst_n(rst_n), .en(en), .gain(cfg.gain), .mode(cfg.mode),
    .valid_i(dv_v[DvdW]), .ratio_i(dv_d[DvdW]), .wgt_i(dv_w[DvdW]),
    .valid_o(fin_v), .wgt_o(fin_w)
  );

  // Output register with skid.
  logic                out_v_r, skid_v_r;
  logic [WeightsW-1:0] out_d_r, skid_d_r;
  logic                pop;

  assign pop        = out_v_r && out_tready;
  assign en         = !skid_v_r;
  assign in_tready  = en;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || pop) begin
      out_v_r <= fin_v;
    end else if (fin_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_d_r <= skid_d_r;
      end
    end else if (!out_v_r || pop) begin
      out_d_r <= fin_w;
    end else begin
      skid_d_r <= fin_w;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid holds an item behind an empty output");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_v_r && !out_tready))
    else $error("input stalled without an output stall");

  a_erase_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && cfg.mode == MODE_ERASE) |-> (out_tdata == '0))
    else $error("erase mode produced a nonzero weight");

  a_paint_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && cfg.mode == MODE_LAYER_A) |-> (out_tdata[15:0] <= 16'(WmaxI)))
    else $error("painted weight above the clamp limit");

endmodule
`default_nettype wire

@@ hw/rtl/tsbw_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// tsbw_sqrt_cell
// One digit cell of the square root chain: retires two radicand bits.
// ----------------------------------------------------------------------------
`default_nettype none
module tsbw_sqrt_cell
  import tsbw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                valid_i,
  input  wire logic [SqRadW-1:0]   rad_i,
  input  wire logic [SqRemW-1:0]   rem_i,
  input  wire logic [RootW-1:0]    root_i,
  input  wire logic [WeightsW-1:0] wgt_i,
  output logic                     valid_o,
  output logic [SqRadW-1:0]        rad_o,
  output logic [SqRemW-1:0]        rem_o,
  output logic [RootW-1:0]         root_o,
  output logic [WeightsW-1:0]      wgt_o
);

  logic [SqRemW-1:0] cur;
  logic [SqRemW-1:0] trial;
  logic              ge;

  always_comb begin
    cur   = {rem_i[SqRemW-3:0], rad_i[SqRadW-1 -: 2]};
    trial = {1'b0, root_i, 2'b01};
    ge    = (cur >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o  <= {rad_i[SqRadW-3:0], 2'b00};
      rem_o  <= ge ? (cur - trial) : cur;
      root_o <= {root_i[RootW-2:0], ge};
      wgt_o  <= wgt_i;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/tsbw_div_cell.sv @@
// ----------------------------------------------------------------------------
// tsbw_div_cell
// One restoring division cell: produces one quotient bit of dist / radius.
// ----------------------------------------------------------------------------
`default_nettype none
module tsbw_div_cell
  import tsbw_pkg::*;
#(
  parameter int DvdW = RootW + FractionBitsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic [RadW-1:0]     radius,
  input  wire logic                valid_i,
  input  wire logic [DvdW-1:0]     dvd_i,
  input  wire logic [RadW-1:0]     rem_i,
  input  wire logic [WeightsW-1:0] wgt_i,
  output logic                     valid_o,
  output logic [DvdW-1:0]          dvd_o,
  output logic [RadW-1:0]          rem_o,
  output logic [WeightsW-1:0]      wgt_o
);

  logic [RadW:0] cur;
  logic [RadW:0] diff;
  logic          ge;

  // The dividend bits shift out at the top while quotient bits fill the bottom.
  always_comb begin
    cur  = {rem_i, dvd_i[DvdW-1]};
    ge   = (cur >= {1'b0, radius});
    diff = cur - {1'b0, radius};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_o <= {dvd_i[DvdW-2:0], ge};
      rem_o <= ge ? diff[RadW-1:0] : cur[RadW-1:0];
      wgt_o <= wgt_i;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/tsbw_cfg.sv @@
// ----------------------------------------------------------------------------
// tsbw_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none
module tsbw_cfg
  import tsbw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  cfg_t       cfg_r;
  logic       wr;
  reg_idx_t   idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CfgAddrW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x <= '0;
      cfg_r.center_z <= '0;
      cfg_r.radius   <= RadW'(256);
      cfg_r.gain     <= GainW'(2560);
      cfg_r.mode     <= MODE_LAYER_A;
    end else if (wr) begin
      case (idx)
        REG_CENTER_X: cfg_r.center_x <= pwdata[CoordW-1:0];
        REG_CENTER_Z: cfg_r.center_z <= pwdata[CoordW-1:0];
        REG_RADIUS:   cfg_r.radius   <= pwdata[RadW-1:0];
        REG_GAIN:     cfg_r.gain     <= pwdata[GainW-1:0];
        REG_MODE:     cfg_r.mode     <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CENTER_X: prdata = {8'd0, cfg_r.center_x};
      REG_CENTER_Z: prdata = {8'd0, cfg_r.center_z};
      REG_RADIUS:   prdata = {8'd0, cfg_r.radius};
      REG_GAIN:     prdata = {8'd0, cfg_r.gain};
      REG_MODE:     prdata = {29'd0, cfg_r.mode};
      default:      prdata = 32'd0;
    endcase
  end

  // A zero radius behaves as one LSB downstream.
  always_comb begin
    cfg = cfg_r;
    if (cfg_r.radius == '0) begin
      cfg.radius = RadW'(1);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/tsbw_weight_unit.sv @@
// ----------------------------------------------------------------------------
// tsbw_weight_unit
// Falloff, gain multiply and clamped update of the selected layer weight, or clearing of all weights in erase mode.
// ----------------------------------------------------------------------------
`default_nettype none
module tsbw_weight_unit
  import tsbw_pkg::*;
#(
  parameter int FractionBits = FractionBitsDefault,
  parameter int DvdW = RootW + FractionBits
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic [GainW-1:0]    gain,
  input  wire logic [2:0]          mode,
  input  wire logic                valid_i,
  input  wire logic [DvdW-1:0]     ratio_i,
  input  wire logic [WeightsW-1:0] wgt_i,
  output logic                     valid_o,
  output logic [WeightsW-1:0]      wgt_o
);

  localparam int XW = (DvdW > MagW) ? DvdW : MagW;
  localparam int WmaxI = ((255 << FractionBits) > 65535) ? 65535 : (255 << FractionBits);
  localparam logic [WeightW-1:0] Wmax = WeightW'(WmaxI);
  localparam logic [XW-1:0] One = XW'(1) << FractionBits;
  localparam logic [XW-1:0] Floor = XW'(1) << 36;

  // Stage 1: sign and saturated magnitude of the falloff.
  logic [XW-1:0]       rx;
  logic [XW-1:0]       diff;
  logic                s1_v_r, s1_neg_r;
  logic [MagW-1:0]     s1_mag_r;
  logic [WeightsW-1:0] s1_w_r;

  always_comb begin
    rx   = XW'(ratio_i);
    diff = (rx > One) ? (rx - One) : (One - rx);
    if (diff > Floor) begin
      diff = Floor;
    end
  end

  // Stage 2: two partial products. Stage 3: sum and scale.
  logic                s2_v_r, s2_neg_r;
  logic [2*GainW-1:0]  s2_lo_r;
  logic [ProdW-GainW-1:0] s2_hi_r;
  logic [WeightsW-1:0] s2_w_r;

  logic                s3_v_r, s3_neg_r;
  logic [ProdW-1:0]    s3_dm_r;
  logic [WeightsW-1:0] s3_w_r;
  logic [ProdW-1:0]    prod;

  assign prod = ProdW'(s2_lo_r) + (ProdW'(s2_hi_r) << GainW);

  // Stage 4: add to or subtract from the chosen layer and clamp; erase mode clears all layers.
  logic [WeightW-1:0]  old;
  logic [ProdW:0]      upd;
  logic [WeightW-1:0]  newv;
  logic [WeightsW-1:0] w4;

  always_comb begin
    old = s3_w_r[WeightW*mode[1:0] +: WeightW];
    if (s3_neg_r) begin
      upd = (ProdW'(old) >= s3_dm_r) ? ((ProdW+1)'(old) - (ProdW+1)'(s3_dm_r)) : '0;
    end else begin
      upd = (ProdW+1)'(old) + (ProdW+1)'(s3_dm_r);
    end
    newv = (upd > (ProdW+1)'(Wmax)) ? Wmax : upd[WeightW-1:0];
    w4 = s3_w_r;
    case (mode)
      MODE_LAYER_A, MODE_LAYER_B, MODE_LAYER_C, MODE_LAYER_D:
        w4[WeightW*mode[1:0] +: WeightW] = newv;
      MODE_ERASE: w4 = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      valid_o <= 1'b0;
    end else if (en) begin
      s1_v_r  <= valid_i;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      valid_o <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_neg_r <= (rx > One);
      s1_mag_r <= diff[MagW-1:0];
      s1_w_r   <= wgt_i;
      s2_neg_r <= s1_neg_r;
      s2_lo_r  <= s1_mag_r[GainW-1:0] * gain;
      s2_hi_r  <= s1_mag_r[MagW-1:GainW] * gain;
      s2_w_r   <= s1_w_r;
      s3_neg_r <= s2_neg_r;
      s3_dm_r  <= prod >> FractionBits;
      s3_w_r   <= s2_w_r;
      wgt_o    <= w4;
    end
  end

endmodule
`default_nettype wire
